[design/successor_page_prefetch_pager_top_macros.svh]
// ----------------------------------------------------------------------------
// successor page prefetch pager assertion macros
// shared property shapes for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SUCCESSOR_PAGE_PREFETCH_PAGER_TOP_MACROS_SVH
`define SUCCESSOR_PAGE_PREFETCH_PAGER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SPP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SPP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/spp_pkg.sv]
// ----------------------------------------------------------------------------
// spp_pkg
// types and constants shared by the successor page prefetch pager
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int unsigned NUM_PROCESSES_DEF     = 32;
  localparam int unsigned PAGES_PER_PROCESS_DEF = 32;
  localparam int unsigned PAGE_SIZE_DEF         = 128;

  localparam int unsigned PROC_W = 5;
  localparam int unsigned PC_W   = 12;
  localparam int unsigned MASK_W = 32;
  localparam int unsigned PAGE_W = 5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_SUB,
    ST_UPD,
    ST_SEL,
    ST_WAIT
  } spp_state_e;

  typedef enum logic {
    CMD_PAGE_OUT = 1'b0,
    CMD_PAGE_IN  = 1'b1
  } spp_cmd_e;

  // one process's command list, handed from the control to the emitter
  typedef struct packed {
    logic              load;
    logic [MASK_W-1:0] out_mask;
    logic              demand;
    logic              prefetch;
    logic [PAGE_W-1:0] cur_page;
    logic [PAGE_W-1:0] pred_page;
    logic [PROC_W-1:0] proc;
  } spp_job_t;

endpackage

[design/spp_ctrl.sv]
// ----------------------------------------------------------------------------
// spp_ctrl
// sequencer, page arithmetic and the previous-page and successor memories
// ----------------------------------------------------------------------------
module spp_ctrl #(
  parameter int unsigned NUM_PROCESSES     = spp_pkg::NUM_PROCESSES_DEF,
  parameter int unsigned PAGES_PER_PROCESS = spp_pkg::PAGES_PER_PROCESS_DEF,
  parameter int unsigned PAGE_SIZE         = spp_pkg::PAGE_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [spp_pkg::PROC_W-1:0]  process_id_i,
  input  logic                        active_i,
  input  logic [spp_pkg::PC_W-1:0]    program_counter_i,
  input  logic [spp_pkg::MASK_W-1:0]  resident_mask_i,
  input  logic                        emit_busy_i,
  output spp_pkg::spp_job_t           job_o
);
  import spp_pkg::*;

  localparam int unsigned PIW   = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int unsigned PW    = $clog2(PAGES_PER_PROCESS);
  localparam int unsigned DEPTH = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int unsigned TAW   = $clog2(DEPTH);
  localparam int unsigned EW    = PW + 1;
  localparam int unsigned RW    = PC_W + 2;
  localparam int unsigned PRODW = PC_W + RW;
  // reciprocal constants, exact for any PC_W-bit numerator
  localparam int unsigned DIV_SH = PC_W + ((PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 0);
  localparam int unsigned DIV_M  = ((32'd1 << DIV_SH) + PAGE_SIZE - 1) / PAGE_SIZE;
  localparam int unsigned MOD_SH = PC_W + PW;
  localparam int unsigned MOD_M  =
    ((32'd1 << MOD_SH) + PAGES_PER_PROCESS - 1) / PAGES_PER_PROCESS;

  spp_state_e state_q, state_d;
  logic [TAW-1:0] clr_q, clr_d;

  logic [PROC_W-1:0] proc_q;
  logic [PIW-1:0]    pidx_q;
  logic              act_q;
  logic [PC_W-1:0]   pc_q;
  logic [MASK_W-1:0] mask_q;
  logic [PC_W-1:0]   q_q;
  logic [PC_W-1:0]   qq_q;
  logic [PW-1:0]     cur_q;
  logic [TAW-1:0]    base_q;

  logic [EW-1:0] prev_mem_q [NUM_PROCESSES];
  logic [EW-1:0] succ_mem_q [DEPTH];
  logic [EW-1:0] prev_rd_q;
  logic [EW-1:0] succ_rd_q;

  logic           prev_we, prev_re;
  logic [PIW-1:0] prev_waddr;
  logic [EW-1:0]  prev_wdata;
  logic           succ_we, succ_re;
  logic [TAW-1:0] succ_waddr, succ_raddr;
  logic [EW-1:0]  succ_wdata;

  logic             accept, in_range;
  logic [PRODW-1:0] prod_div, prod_mod;
  logic [PC_W-1:0]  rem;
  logic             prev_vld, moved;
  logic [PW-1:0]    prev_pg;
  logic             have_pred;
  logic [PW-1:0]    pred;
  logic [MASK_W-1:0] cur_sh, pred_sh;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(process_id_i) < NUM_PROCESSES);

  assign prod_div = PRODW'(pc_q) * PRODW'(DIV_M);
  assign prod_mod = PRODW'(q_q) * PRODW'(MOD_M);
  assign rem      = q_q - PC_W'(qq_q * PC_W'(PAGES_PER_PROCESS));

  assign prev_vld = prev_rd_q[PW];
  assign prev_pg  = prev_rd_q[PW-1:0];
  assign moved    = prev_vld && (prev_pg != cur_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == TAW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_range) state_d = active_i ? ST_DIV : ST_SEL;
      end
      ST_DIV:  state_d = ST_MOD;
      ST_MOD:  state_d = ST_SUB;
      ST_SUB:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_SEL;
      ST_SEL:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (!emit_busy_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    prev_we    = 1'b0;
    prev_re    = 1'b0;
    prev_waddr = pidx_q;
    prev_wdata = {1'b1, cur_q};
    succ_we    = 1'b0;
    succ_re    = 1'b0;
    succ_waddr = base_q + TAW'(prev_pg);
    succ_raddr = base_q + TAW'(cur_q);
    succ_wdata = {1'b1, cur_q};
    clr_d      = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d      = clr_q + TAW'(1);
        succ_we    = 1'b1;
        succ_waddr = clr_q;
        succ_wdata = '0;
        prev_we    = (clr_q < TAW'(NUM_PROCESSES));
        prev_waddr = clr_q[PIW-1:0];
        prev_wdata = '0;
      end
      ST_MOD: begin
        prev_re = 1'b1;
      end
      ST_UPD: begin
        // read address is the current page, write address the old one: never equal
        prev_we = !prev_vld || (prev_pg != cur_q);
        succ_we = moved;
        succ_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // command list for the emitter
  always_comb begin
    have_pred = act_q && succ_rd_q[PW];
    pred      = succ_rd_q[PW-1:0];
    cur_sh    = mask_q >> cur_q;
    pred_sh   = mask_q >> pred;
    job_o.load = (state_q == ST_SEL);
    for (int p = 0; p < MASK_W; p++) begin
      job_o.out_mask[p] = mask_q[p] && (p < PAGES_PER_PROCESS)
                          && !(act_q && (32'(cur_q) == 32'(p)))
                          && !(have_pred && (32'(pred) == 32'(p)));
    end
    job_o.demand    = act_q && !cur_sh[0];
    job_o.prefetch  = have_pred && !pred_sh[0];
    job_o.cur_page  = PAGE_W'(cur_q);
    job_o.pred_page = PAGE_W'(pred);
    job_o.proc      = proc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      proc_q <= process_id_i;
      pidx_q <= PIW'(process_id_i);
      act_q  <= active_i;
      pc_q   <= program_counter_i;
      mask_q <= resident_mask_i;
    end
    if (state_q == ST_DIV) begin
      q_q    <= PC_W'(prod_div >> DIV_SH);
      base_q <= TAW'(32'(pidx_q) * PAGES_PER_PROCESS);
    end
    if (state_q == ST_MOD) qq_q <= PC_W'(prod_mod >> MOD_SH);
    if (state_q == ST_SUB) cur_q <= PW'(rem);
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem_q[prev_waddr] <= prev_wdata;
    if (prev_re) prev_rd_q <= prev_mem_q[pidx_q];
  end

  always_ff @(posedge clk_i) begin
    if (succ_we) succ_mem_q[succ_waddr] <= succ_wdata;
    if (succ_re) succ_rd_q <= succ_mem_q[succ_raddr];
  end

endmodule

[design/spp_emit.sv]
// ----------------------------------------------------------------------------
// spp_emit
// walks one process's command list and drives the output register
// ----------------------------------------------------------------------------
module spp_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spp_pkg::spp_job_t           job_i,
  output logic                        emit_busy_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        command_o,
  output logic [spp_pkg::PROC_W-1:0]  target_process_o,
  output logic [spp_pkg::PAGE_W-1:0]  page_number_o,
  output logic                        last_command_o
);
  import spp_pkg::*;

  logic [MASK_W-1:0] pend_q, pend_d;
  logic              dem_q, dem_d;
  logic              pref_q, pref_d;
  logic [PAGE_W-1:0] cur_q, pred_q;
  logic [PROC_W-1:0] proc_q;

  logic              out_valid_q, out_valid_d;
  spp_cmd_e          cmd_q;
  logic [PROC_W-1:0] tgt_q;
  logic [PAGE_W-1:0] page_q;
  logic              last_q;

  logic              slot_free, take;
  logic [PAGE_W-1:0] hi;
  logic [MASK_W-1:0] rest;
  spp_cmd_e          w_cmd;
  logic [PAGE_W-1:0] w_page;
  logic              w_last;

  assign emit_busy_o = (|pend_q) || dem_q || pref_q;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign take        = slot_free && emit_busy_o;

  // highest pending page-out goes first
  always_comb begin
    hi = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (pend_q[i]) hi = PAGE_W'(i);
    end
    rest = pend_q & ~(MASK_W'(1) << hi);
  end

  always_comb begin
    if (|pend_q) begin
      w_cmd  = CMD_PAGE_OUT;
      w_page = hi;
      w_last = !(|rest) && !dem_q && !pref_q;
    end else if (dem_q) begin
      w_cmd  = CMD_PAGE_IN;
      w_page = cur_q;
      w_last = !pref_q;
    end else begin
      w_cmd  = CMD_PAGE_IN;
      w_page = pred_q;
      w_last = 1'b1;
    end
  end

  always_comb begin
    pend_d = pend_q;
    dem_d  = dem_q;
    pref_d = pref_q;
    if (job_i.load) begin
      pend_d = job_i.out_mask;
      dem_d  = job_i.demand;
      pref_d = job_i.prefetch;
    end else if (take) begin
      if (|pend_q) pend_d = rest;
      else if (dem_q) dem_d = 1'b0;
      else pref_d = 1'b0;
    end
    out_valid_d = slot_free ? take : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      dem_q       <= 1'b0;
      pref_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      dem_q       <= dem_d;
      pref_q      <= pref_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.load) begin
      cur_q  <= job_i.cur_page;
      pred_q <= job_i.pred_page;
      proc_q <= job_i.proc;
    end
    if (take) begin
      cmd_q  <= w_cmd;
      tgt_q  <= proc_q;
      page_q <= w_page;
      last_q <= w_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign command_o        = cmd_q;
  assign target_process_o = tgt_q;
  assign page_number_o    = page_q;
  assign last_command_o   = last_q;

endmodule

[design/successor_page_prefetch_pager_top.sv]
// ----------------------------------------------------------------------------
// successor_page_prefetch_pager_top
// first-order successor page prefetcher issuing page-out and page-in commands
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | process_id, active, pc, mask
//   out     | output    | out_valid_o / out_stall_i | command, process, page, last
//
// an active item passes three steps of page arithmetic with the previous-page
//   read, one read-modify-write of both memories, a hand-off to the emitter,
//   one output word per cycle while out_stall_i is low and a wait for the
//   emitter to drain; an inactive item skips the arithmetic and memory steps
// after reset a clearing pass writes NUM_PROCESSES * PAGES_PER_PROCESS
//   successor entries with the input stalled
// output stalls hold the emitter; the next item is taken while the final
//   word still waits in the output register
// ----------------------------------------------------------------------------
module successor_page_prefetch_pager_top #(
  parameter int unsigned NUM_PROCESSES     = spp_pkg::NUM_PROCESSES_DEF,
  parameter int unsigned PAGES_PER_PROCESS = spp_pkg::PAGES_PER_PROCESS_DEF,
  parameter int unsigned PAGE_SIZE         = spp_pkg::PAGE_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [spp_pkg::PROC_W-1:0]  process_id_i,
  input  logic                        active_i,
  input  logic [spp_pkg::PC_W-1:0]    program_counter_i,
  input  logic [spp_pkg::MASK_W-1:0]  resident_mask_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        command_o,
  output logic [spp_pkg::PROC_W-1:0]  target_process_o,
  output logic [spp_pkg::PAGE_W-1:0]  page_number_o,
  output logic                        last_command_o
);
  import spp_pkg::*;

  spp_job_t job;
  logic     emit_busy;

  spp_ctrl #(
    .NUM_PROCESSES     (NUM_PROCESSES),
    .PAGES_PER_PROCESS (PAGES_PER_PROCESS),
    .PAGE_SIZE         (PAGE_SIZE)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .process_id_i      (process_id_i),
    .active_i          (active_i),
    .program_counter_i (program_counter_i),
    .resident_mask_i   (resident_mask_i),
    .emit_busy_i       (emit_busy),
    .job_o             (job)
  );

  spp_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (job),
    .emit_busy_o      (emit_busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .command_o        (command_o),
    .target_process_o (target_process_o),
    .page_number_o    (page_number_o),
    .last_command_o   (last_command_o)
  );

endmodule

[design/spp_checker.sv]
// ----------------------------------------------------------------------------
// spp_checker
// port-level checks for the successor page prefetch pager
// ----------------------------------------------------------------------------
`include "successor_page_prefetch_pager_top_macros.svh"

module spp_checker #(
  parameter int unsigned NUM_PROCESSES = spp_pkg::NUM_PROCESSES_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [spp_pkg::PROC_W-1:0]  process_id_i,
  input logic                        active_i,
  input logic [spp_pkg::PC_W-1:0]    program_counter_i,
  input logic [spp_pkg::MASK_W-1:0]  resident_mask_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        command_o,
  input logic [spp_pkg::PROC_W-1:0]  target_process_o,
  input logic [spp_pkg::PAGE_W-1:0]  page_number_o,
  input logic                        last_command_o
);

  // a stalled word stays put
  `SPP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(command_o) && $stable(target_process_o) && $stable(page_number_o) && $stable(last_command_o), "stalled output word changed")

  // more words of this item to come, so no new item may enter
  `SPP_ASSERT_IMP(a_busy_mid_item, out_valid_o && !last_command_o, in_stall_o, "input open before final word of item")

  // an item for a known process always occupies the sequencer
  `SPP_ASSERT_NXT(a_stall_after_take, in_valid_i && !in_stall_o && (32'(process_id_i) < NUM_PROCESSES), in_stall_o, "no stall after accepted item")

endmodule

bind successor_page_prefetch_pager_top spp_checker #(
  .NUM_PROCESSES (NUM_PROCESSES)
) u_spp_checker (.*);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for successor_page_prefetch_pager_top
// drives process status words, predicts every page command in a local model
// of the successor tables and checks the command stream word by word, under
// changing sender gaps, receiver stalls and one long receiver hold-off
// ----------------------------------------------------------------------------
module testbench;
  import spp_pkg::*;

  localparam int unsigned PAGES    = PAGES_PER_PROCESS_DEF;
  localparam int unsigned PROCS    = NUM_PROCESSES_DEF;
  localparam int unsigned PG_BYTES = PAGE_SIZE_DEF;
  localparam int unsigned SETTLE   = 48;

  typedef struct {
    spp_cmd_e          cmd;
    logic [PROC_W-1:0] proc;
    logic [PAGE_W-1:0] page;
    logic              last;
  } page_cmd_t;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_stall_o;
  logic [PROC_W-1:0] process_id_i      = '0;
  logic              active_i          = 1'b0;
  logic [PC_W-1:0]   program_counter_i = '0;
  logic [MASK_W-1:0] resident_mask_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i       = 1'b0;
  logic              command_o;
  logic [PROC_W-1:0] target_process_o;
  logic [PAGE_W-1:0] page_number_o;
  logic              last_command_o;

  // local copy of the pager state
  logic              seen_valid [PROCS];
  logic [PAGE_W-1:0] seen_page  [PROCS];
  logic              succ_valid [PROCS*PAGES];
  logic [PAGE_W-1:0] succ_page  [PROCS*PAGES];

  page_cmd_t pending_cmds[$];
  page_cmd_t head_cmd;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_request = 0;
  int hold_left    = 0;
  int errors       = 0;

  successor_page_prefetch_pager_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .process_id_i     (process_id_i),
    .active_i         (active_i),
    .program_counter_i(program_counter_i),
    .resident_mask_i  (resident_mask_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .command_o        (command_o),
    .target_process_o (target_process_o),
    .page_number_o    (page_number_o),
    .last_command_o   (last_command_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void push_cmd(spp_cmd_e cmd, logic [PROC_W-1:0] proc,
                                   logic [PAGE_W-1:0] page);
    page_cmd_t w;
    w.cmd  = cmd;
    w.proc = proc;
    w.page = page;
    w.last = 1'b0;
    pending_cmds.push_back(w);
  endfunction

  function automatic void predict_commands(logic [PROC_W-1:0] pid, logic act,
                                           logic [PC_W-1:0] pc,
                                           logic [MASK_W-1:0] mask);
    logic [PAGE_W-1:0] cur;
    logic [PAGE_W-1:0] pred;
    logic              have_pred;
    int                base;
    int                first;
    cur       = '0;
    pred      = '0;
    have_pred = 1'b0;
    base      = int'(pid) * PAGES;
    first     = pending_cmds.size();
    if (act) begin
      cur = PAGE_W'((int'(pc) / PG_BYTES) % PAGES);
      if (!seen_valid[pid]) begin
        seen_valid[pid] = 1'b1;
        seen_page[pid]  = cur;
      end else if (seen_page[pid] != cur) begin
        // record the transition out of the previous page
        succ_valid[base + int'(seen_page[pid])] = 1'b1;
        succ_page[base + int'(seen_page[pid])]  = cur;
        seen_page[pid] = cur;
      end
      have_pred = succ_valid[base + int'(cur)];
      pred      = succ_page[base + int'(cur)];
    end
    for (int p = PAGES - 1; p >= 0; p--) begin
      if (mask[p] && !(act && (PAGE_W'(p) == cur || (have_pred && PAGE_W'(p) == pred))))
        push_cmd(CMD_PAGE_OUT, pid, PAGE_W'(p));
    end
    if (act) begin
      if (!mask[cur]) push_cmd(CMD_PAGE_IN, pid, cur);
      if (have_pred && !mask[pred]) push_cmd(CMD_PAGE_IN, pid, pred);
    end
    if (pending_cmds.size() > first) pending_cmds[pending_cmds.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual cmd %0d proc %0d page %0d",
                 $time, command_o, target_process_o, page_number_o);
        errors++;
      end else begin
        head_cmd = pending_cmds.pop_front();
        check_field("command", int'(head_cmd.cmd), int'(command_o));
        check_field("target_process", int'(head_cmd.proc), int'(target_process_o));
        check_field("page_number", int'(head_cmd.page), int'(page_number_o));
        check_field("last_command", int'(head_cmd.last), int'(last_command_o));
      end
    end
  end

  // receiver: random stalls, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_status(input logic [PROC_W-1:0] pid, input logic act,
                             input logic [PC_W-1:0] pc, input logic [MASK_W-1:0] mask);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    process_id_i      <= pid;
    active_i          <= act;
    program_counter_i <= pc;
    resident_mask_i   <= mask;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_commands(pid, act, pc, mask);
  endtask

  task automatic park_and_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cmds.size() != 0) @(posedge clk_i);
    // a word with no commands may still be in flight
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic test_first_sighting();
    send_status(5'd0, 1'b1, 12'd0, 32'h0);          // demand page-in only
    send_status(5'd0, 1'b1, 12'd127, 32'h1);        // same page, resident: nothing
    send_status(5'd0, 1'b1, 12'd128 * 3, '1);       // 0 -> 3, page out all but 3
    send_status(5'd0, 1'b1, 12'd0, '1);             // 3 -> 0, predicts 3
    send_status(5'd0, 1'b1, 12'd5, 32'h0);          // demand 0 and prefetch 3
    send_status(5'd0, 1'b1, 12'd64, 32'h9);         // current and predicted resident
  endtask

  task automatic test_prediction_chain();
    send_status(5'd31, 1'b1, 12'd4095, 32'h8000_0000);
    send_status(5'd31, 1'b1, 12'd0, 32'h0);
    send_status(5'd31, 1'b1, 12'd4095, 32'h0);      // predicts page 0
    send_status(5'd31, 1'b1, 12'd128, 32'hAAAA_5555);
    send_status(5'd31, 1'b1, 12'd4095, 32'h5555_AAAA);
    send_status(5'd31, 1'b1, 12'd256, 32'h8000_0001);
    send_status(5'd17, 1'b1, 12'd2048, 32'hFFFF_0000);
    send_status(5'd17, 1'b1, 12'd2048, 32'h0000_FFFF);
  endtask

  task automatic test_inactive_release();
    send_status(5'd0, 1'b0, 12'd0, '1);             // all 32 page-outs
    send_status(5'd0, 1'b0, 12'd4095, 32'h0);       // nothing at all
    send_status(5'd31, 1'b0, 12'd1234, 32'h8000_0001);
    send_status(5'd0, 1'b1, 12'd0, 32'h8);          // state kept across inactive
    send_status(5'd9, 1'b0, 12'd77, 32'h0000_0100);
  endtask

  task automatic random_status(input int count);
    logic [PROC_W-1:0] pid;
    logic [PC_W-1:0]   pc;
    logic [MASK_W-1:0] mask;
    logic              act;
    int                page;
    repeat (count) begin
      pid = $urandom_range(1) ? PROC_W'($urandom_range(31)) : PROC_W'($urandom_range(3));
      act = ($urandom_range(99) < 85);
      if ($urandom_range(99) < 75) begin
        // walk over a few pages of this process so successors get reused
        page = (int'(pid) + 7 * $urandom_range(3)) % PAGES;
        pc   = PC_W'(page * PG_BYTES + $urandom_range(PG_BYTES - 1));
      end else begin
        pc = PC_W'($urandom_range(4095));
      end
      case ($urandom_range(5))
        0:       mask = '0;
        1:       mask = '1;
        2:       mask = (32'h1 << $urandom_range(31)) | (32'h1 << $urandom_range(31));
        3:       mask = $urandom & $urandom;
        default: mask = $urandom;
      endcase
      send_status(pid, act, pc, mask);
    end
  endtask

  task automatic test_random_phases();
    idle_pct = 0;  stall_pct = 0;  random_status(90);
    idle_pct = 79; stall_pct = 0;  random_status(90);
    idle_pct = 0;  stall_pct = 79; random_status(90);
    idle_pct = 10; stall_pct = 10; random_status(90);
  endtask

  task automatic test_output_hold_off();
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 400;
    repeat (12) send_status(PROC_W'($urandom_range(31)), 1'b1,
                            PC_W'($urandom_range(4095)), '1);
    park_and_drain();
  endtask

  task automatic test_sender_pause();
    idle_pct  = 10;
    stall_pct = 30;
    random_status(10);
    park_and_drain();
    random_status(10);
  endtask

  initial begin
    for (int i = 0; i < PROCS; i++) begin
      seen_valid[i] = 1'b0;
      seen_page[i]  = '0;
    end
    for (int i = 0; i < PROCS * PAGES; i++) begin
      succ_valid[i] = 1'b0;
      succ_page[i]  = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_first_sighting();
    test_prediction_chain();
    test_inactive_release();
    test_random_phases();
    test_output_hold_off();
    test_sender_pause();
    park_and_drain();
    if (errors == 0) begin
      $display("successor_page_prefetch_pager_top test passed");
    end else begin
      $display("successor_page_prefetch_pager_top test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("successor_page_prefetch_pager_top test failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/spp_pkg.sv
design/spp_ctrl.sv
design/spp_emit.sv
design/successor_page_prefetch_pager_top.sv
design/spp_checker.sv
sim/testbench.sv
